### src/wlmf_pkg.sv
// wlmf_pkg: shared constants, register indexes and control types of the
// windowed label mode filter. No dependencies.

package wlmf_pkg;

  localparam int MAX_WINDOW = 32;
  localparam int LABEL_BITS = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 2'd1;

  localparam logic [CFG_DATA_W-1:0] MIN_COUNT_RST  = 6'd1;
  localparam logic [CFG_DATA_W-1:0] WINDOW_LEN_RST = 6'd5;

  // window store control
  typedef struct packed {
    logic push;
    logic clear;
  } wlmf_win_ctrl_t;

  // sequencer status
  typedef struct packed {
    logic clearing;
    logic idle;
  } wlmf_status_t;

endpackage

### src/wlmf_if.sv
// wlmf channel interfaces: label input, filtered label output, config write.
// Depends on wlmf_pkg.

interface wlmf_in_if #(
  parameter int LabelBits = wlmf_pkg::LABEL_BITS
);
  logic                 valid;
  logic                 ready;
  logic [LabelBits-1:0] class_label;

  modport source (output valid, output class_label, input ready);
  modport sink   (input valid, input class_label, output ready);
endinterface

interface wlmf_out_if #(
  parameter int LabelBits = wlmf_pkg::LABEL_BITS
);
  logic                 valid;
  logic                 ready;
  logic [LabelBits-1:0] filtered_label;

  modport source (output valid, output filtered_label, input ready);
  modport sink   (input valid, input filtered_label, output ready);
endinterface

interface wlmf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [wlmf_pkg::CFG_IDX_W-1:0]  index;
  logic [wlmf_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### src/wlmf_window.sv
// wlmf_window: circular store of the most recent labels and its write pointer.
// Depends on wlmf_pkg.

module wlmf_window #(
  parameter int MaxWindow = wlmf_pkg::MAX_WINDOW,
  parameter int LabelBits = wlmf_pkg::LABEL_BITS,
  parameter int PtrW      = (MaxWindow > 1) ? $clog2(MaxWindow) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  wlmf_pkg::wlmf_win_ctrl_t ctrl_i,
  input  logic [LabelBits-1:0]     push_label_i,
  input  logic [PtrW-1:0]          rd_idx_i,
  output logic [LabelBits-1:0]     rd_label_o,
  output logic [PtrW-1:0]          wr_pos_o
);
  import wlmf_pkg::*;

  localparam logic [PtrW-1:0] LastPos = PtrW'(MaxWindow - 1);

  logic [LabelBits-1:0] win_q [MaxWindow];
  logic [PtrW-1:0]      wr_pos_q, wr_pos_d;

  always_comb begin
    wr_pos_d = wr_pos_q;
    if (ctrl_i.clear) begin
      wr_pos_d = '0;
    end else if (ctrl_i.push) begin
      wr_pos_d = (wr_pos_q == LastPos) ? '0 : wr_pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pos_q <= '0;
      for (int k = 0; k < MaxWindow; k++) win_q[k] <= '0;
    end else begin
      wr_pos_q <= wr_pos_d;
      if (ctrl_i.clear) begin
        for (int k = 0; k < MaxWindow; k++) win_q[k] <= '0;
      end else if (ctrl_i.push) begin
        win_q[wr_pos_q] <= push_label_i;
      end
    end
  end

  assign rd_label_o = win_q[rd_idx_i];
  assign wr_pos_o   = wr_pos_q;

endmodule

### src/wlmf_count_mem.sv
// wlmf_count_mem: per-label running count memory, one write and one
// registered read port. Depends on wlmf_pkg.

module wlmf_count_mem #(
  parameter int LabelBits = wlmf_pkg::LABEL_BITS,
  parameter int CntW      = $clog2(wlmf_pkg::MAX_WINDOW + 1)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [LabelBits-1:0] waddr_i,
  input  logic [CntW-1:0]      wdata_i,
  input  logic [LabelBits-1:0] raddr_i,
  output logic [CntW-1:0]      rdata_o
);
  import wlmf_pkg::*;

  localparam int Depth = 2 ** LabelBits;

  logic [CntW-1:0] mem_q [Depth];
  logic [CntW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/wlmf_scan.sv
// wlmf_scan: sequencer that walks the window through the count memory,
// tracks the leading label and holds the result register.
// Depends on wlmf_pkg.

module wlmf_scan #(
  parameter int MaxWindow = wlmf_pkg::MAX_WINDOW,
  parameter int LabelBits = wlmf_pkg::LABEL_BITS,
  parameter int PtrW      = (MaxWindow > 1) ? $clog2(MaxWindow) : 1,
  parameter int CntW      = $clog2(MaxWindow + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [LabelBits-1:0]           filtered_label_o,
  input  logic [wlmf_pkg::CFG_DATA_W-1:0] min_count_i,
  input  logic [CntW-1:0]                len_i,
  input  logic [PtrW-1:0]                wr_pos_i,
  output logic                           push_o,
  output logic [PtrW-1:0]                rd_idx_o,
  input  logic [LabelBits-1:0]           rd_label_i,
  output logic                           mem_we_o,
  output logic [LabelBits-1:0]           mem_waddr_o,
  output logic [CntW-1:0]                mem_wdata_o,
  output logic [LabelBits-1:0]           mem_raddr_o,
  input  logic [CntW-1:0]                mem_rdata_i,
  output wlmf_pkg::wlmf_status_t         status_o
);
  import wlmf_pkg::*;

  localparam logic [PtrW-1:0] LastPos = PtrW'(MaxWindow - 1);
  localparam int              CmpW    = (CntW > CFG_DATA_W) ? CntW : CFG_DATA_W;
  localparam int              DiffW   = CntW + 1;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_START = 7'b0000100,
    ST_SCAN  = 7'b0001000,
    ST_DRAIN = 7'b0010000,
    ST_UNDO  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e               state_q, state_d;
  logic [LabelBits-1:0] clr_q, clr_d;
  logic [PtrW-1:0]      idx_q, idx_d, start_q, start_d, idx_nxt;
  logic [CntW-1:0]      rem_q, rem_d, len_q, len_d;
  logic                 p1_valid_q, p1_valid_d, p1_first_q, p1_first_d;
  logic [LabelBits-1:0] p1_label_q, p1_label_d;
  logic                 wb_valid_q;
  logic [LabelBits-1:0] wb_label_q;
  logic [CntW-1:0]      wb_cnt_q;
  logic [LabelBits-1:0] lead_label_q, lead_label_d;
  logic [CntW-1:0]      lead_cnt_q, lead_cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic [LabelBits-1:0] out_label_q, out_label_d;
  logic [CntW-1:0]      cnt_base, cnt_new;
  logic [DiffW-1:0]     start_diff;
  logic                 out_free, qualifies;

  assign idx_nxt  = (idx_q == LastPos) ? '0 : idx_q + 1'b1;
  assign out_free = !out_valid_q || out_ready_i;

  // oldest window entry: write pointer minus length, modulo the capacity
  always_comb begin
    start_diff = DiffW'(wr_pos_i) - DiffW'(len_i);
    if (start_diff[DiffW-1]) begin
      start_diff = start_diff + DiffW'(MaxWindow);
    end
  end

  // second stage: running count, forwarded from the previous write when the labels match
  assign cnt_base  = (wb_valid_q && (wb_label_q == p1_label_q)) ? wb_cnt_q : mem_rdata_i;
  assign cnt_new   = cnt_base + 1'b1;
  assign qualifies = CmpW'(lead_cnt_q) >= CmpW'(min_count_i);

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    idx_d        = idx_q;
    start_d      = start_q;
    rem_d        = rem_q;
    len_d        = len_q;
    p1_valid_d   = 1'b0;
    p1_first_d   = 1'b0;
    p1_label_d   = rd_label_i;
    lead_label_d = lead_label_q;
    lead_cnt_d   = lead_cnt_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_label_d  = out_label_q;
    in_ready_o   = 1'b0;
    push_o       = 1'b0;
    mem_we_o     = 1'b0;
    mem_waddr_o  = rd_label_i;
    mem_wdata_o  = '0;

    if (p1_valid_q) begin
      mem_we_o    = 1'b1;
      mem_waddr_o = p1_label_q;
      mem_wdata_o = cnt_new;
      if (p1_first_q) begin
        lead_label_d = p1_label_q;
        lead_cnt_d   = CntW'(1);
      end else if ((cnt_new > lead_cnt_q) && (p1_label_q != '0)) begin
        lead_label_d = p1_label_q;
        lead_cnt_d   = cnt_new;
      end
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        clr_d       = clr_q + 1'b1;
        if (clr_q == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          push_o  = 1'b1;
          state_d = ST_START;
        end
      end
      ST_START: begin
        start_d = PtrW'(start_diff);
        idx_d   = PtrW'(start_diff);
        rem_d   = len_i;
        len_d   = len_i;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        p1_valid_d = 1'b1;
        p1_first_d = (rem_q == len_q);
        idx_d      = idx_nxt;
        rem_d      = rem_q - 1'b1;
        if (rem_q == CntW'(1)) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        idx_d   = start_q;
        rem_d   = len_q;
        state_d = ST_UNDO;
      end
      ST_UNDO: begin
        // put the touched counters back to zero for the next transaction
        mem_we_o    = 1'b1;
        mem_waddr_o = rd_label_i;
        idx_d       = idx_nxt;
        rem_d       = rem_q - 1'b1;
        if (rem_q == CntW'(1)) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_label_d = qualifies ? lead_label_q : '0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      p1_valid_q  <= 1'b0;
      wb_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      p1_valid_q  <= p1_valid_d;
      wb_valid_q  <= p1_valid_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    start_q      <= start_d;
    rem_q        <= rem_d;
    len_q        <= len_d;
    p1_first_q   <= p1_first_d;
    p1_label_q   <= p1_label_d;
    wb_label_q   <= p1_label_q;
    wb_cnt_q     <= cnt_new;
    lead_label_q <= lead_label_d;
    lead_cnt_q   <= lead_cnt_d;
    out_label_q  <= out_label_d;
  end

  assign rd_idx_o          = idx_q;
  assign mem_raddr_o       = rd_label_i;
  assign out_valid_o       = out_valid_q;
  assign filtered_label_o  = out_label_q;
  assign status_o.clearing = (state_q == ST_CLEAR);
  assign status_o.idle     = (state_q == ST_IDLE);

endmodule

### src/windowed_label_mode_filter_unit.sv
// windowed_label_mode_filter_unit: top level with config registers, window
// store, count memory and scan sequencer. Depends on wlmf_pkg and wlmf_if.
//
//   channel      dir   payload                      transaction
//   label_in_i   in    class_label                  valid & ready
//   label_out_o  out   filtered_label               valid & ready
//   cfg_i        in    index, data                  valid & ready (ready is always high)
//
// in one transaction the count memory is walked along the effective window once to
// count and once to zero the counters
// after reset a clearing pass over all 2**LabelBits counters (256 by default) keeps ready low
// a config write to a defined register clears the window and write pointer
// a result waits in the output register; the next label is taken meanwhile

module windowed_label_mode_filter_unit #(
  parameter int MaxWindow = wlmf_pkg::MAX_WINDOW,
  parameter int LabelBits = wlmf_pkg::LABEL_BITS
) (
  input logic        clk_i,
  input logic        rst_ni,
  wlmf_in_if.sink    label_in_i,
  wlmf_out_if.source label_out_o,
  wlmf_cfg_if.sink   cfg_i
);
  import wlmf_pkg::*;

  localparam int PtrW = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
  localparam int CntW = $clog2(MaxWindow + 1);

  logic [CFG_DATA_W-1:0] min_count_q, min_count_d;
  logic [CFG_DATA_W-1:0] window_len_q, window_len_d;
  logic                  cfg_write, cfg_hit;
  logic [CntW-1:0]       eff_len;
  wlmf_win_ctrl_t        win_ctrl;
  wlmf_status_t          status;
  logic                  push;
  logic [PtrW-1:0]       rd_idx, wr_pos;
  logic [LabelBits-1:0]  rd_label;
  logic                  mem_we;
  logic [LabelBits-1:0]  mem_waddr, mem_raddr;
  logic [CntW-1:0]       mem_wdata, mem_rdata;

  assign cfg_i.ready = 1'b1;
  assign cfg_write   = cfg_i.valid && cfg_i.ready;

  always_comb begin
    min_count_d  = min_count_q;
    window_len_d = window_len_q;
    cfg_hit      = 1'b0;
    if (cfg_write) begin
      unique case (cfg_i.index)
        REG_MIN_COUNT: begin
          min_count_d = cfg_i.data;
          cfg_hit     = 1'b1;
        end
        REG_WINDOW_LEN: begin
          window_len_d = cfg_i.data;
          cfg_hit      = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_count_q  <= MIN_COUNT_RST;
      window_len_q <= WINDOW_LEN_RST;
    end else begin
      min_count_q  <= min_count_d;
      window_len_q <= window_len_d;
    end
  end

  // zero means one entry, anything above the capacity saturates
  always_comb begin
    if (window_len_q == '0) begin
      eff_len = CntW'(1);
    end else if (int'(window_len_q) > MaxWindow) begin
      eff_len = CntW'(MaxWindow);
    end else begin
      eff_len = CntW'(window_len_q);
    end
  end

  assign win_ctrl.push  = push;
  assign win_ctrl.clear = cfg_hit;

  wlmf_window #(
    .MaxWindow (MaxWindow),
    .LabelBits (LabelBits),
    .PtrW      (PtrW)
  ) u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (win_ctrl),
    .push_label_i (label_in_i.class_label),
    .rd_idx_i     (rd_idx),
    .rd_label_o   (rd_label),
    .wr_pos_o     (wr_pos)
  );

  wlmf_count_mem #(
    .LabelBits (LabelBits),
    .CntW      (CntW)
  ) u_count_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  wlmf_scan #(
    .MaxWindow (MaxWindow),
    .LabelBits (LabelBits),
    .PtrW      (PtrW),
    .CntW      (CntW)
  ) u_scan (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (label_in_i.valid),
    .in_ready_o       (label_in_i.ready),
    .out_valid_o      (label_out_o.valid),
    .out_ready_i      (label_out_o.ready),
    .filtered_label_o (label_out_o.filtered_label),
    .min_count_i      (min_count_q),
    .len_i            (eff_len),
    .wr_pos_i         (wr_pos),
    .push_o           (push),
    .rd_idx_o         (rd_idx),
    .rd_label_i       (rd_label),
    .mem_we_o         (mem_we),
    .mem_waddr_o      (mem_waddr),
    .mem_wdata_o      (mem_wdata),
    .mem_raddr_o      (mem_raddr),
    .mem_rdata_i      (mem_rdata),
    .status_o         (status)
  );

`ifndef SYNTH
  a_cfg_clears_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> (wr_pos == '0))
    else $error("write pointer not cleared after config write");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (label_in_i.valid && label_in_i.ready) |=> !label_in_i.ready)
    else $error("ready still high after an accepted transaction");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.clearing |-> (!label_in_i.ready && !label_out_o.valid && !status.idle))
    else $error("channel active during counter clearing pass");
`endif

endmodule
